// File: rtl/dwfp_pkg.sv
// dwfp_pkg: shared types and constants of the dyck word flip pair block
package dwfp_pkg;

    // default cap on the half length
    localparam int DWFP_MAX_HALF = 16;

    // word and field widths
    localparam int WORD_W = 32;
    localparam int POS_W  = 5;
    localparam int HALF_W = 5;
    localparam int N_W    = 6;
    localparam int CNT_W  = 6;
    localparam int H_W    = 7;

    // status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NO_FIRST  = 2'd1;
    localparam logic [1:0] STATUS_NO_SECOND = 2'd2;

    // one word in flight along the chain of cells
    typedef struct packed {
        logic                    vld;
        logic [WORD_W-1:0]       w;
        logic signed [H_W-1:0]   h;
        logic [CNT_W-1:0]        cnt;
        logic                    hit;
        logic [POS_W-1:0]        pos;
        logic [WORD_W-1:0]       y;
        logic [POS_W-1:0]        a;
        logic                    first_hit;
    } dwfp_item_t;

endpackage

// File: rtl/dwfp_count_cell.sv
// dwfp_count_cell: one step of the counting row, tracks height and counts matching steps
module dwfp_count_cell
    import dwfp_pkg::*;
#(
    parameter int IDX     = 0,
    parameter bit WANT_UP = 1'b0
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic [N_W-1:0]   n,
    input  dwfp_item_t       item_in,
    output dwfp_item_t       item_out
);

    localparam logic signed [H_W-1:0] H_MATCH = WANT_UP ? H_W'(1) : H_W'(0);

    dwfp_item_t item_reg;
    dwfp_item_t item_next;

    // count the step if it matches, then move the height
    always_comb
    begin
        logic up;
        logic active;
        up        = item_in.w[IDX];
        active    = N_W'(IDX) < n;
        item_next = item_in;
        if (active)
        begin
            if ((up == WANT_UP) && (item_in.h == H_MATCH))
            begin
                item_next.cnt = item_in.cnt + CNT_W'(1);
            end
            item_next.h = up ? (item_in.h + H_W'(1)) : (item_in.h - H_W'(1));
        end
    end

    // stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_reg <= '0;
        end
        else if (adv)
        begin
            item_reg <= item_next;
        end
    end

    assign item_out = item_reg;

endmodule

// File: rtl/dwfp_select_cell.sv
// dwfp_select_cell: one step of the selection row, flips the target candidate step
module dwfp_select_cell
    import dwfp_pkg::*;
#(
    parameter int IDX     = 0,
    parameter bit WANT_UP = 1'b0
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic [N_W-1:0]   n,
    input  dwfp_item_t       item_in,
    output dwfp_item_t       item_out
);

    dwfp_item_t item_reg;
    dwfp_item_t item_next;

    // cnt counts the candidates still to come up to and including the target
    always_comb
    begin
        logic up;
        logic active;
        logic cand;
        up        = item_in.w[IDX];
        active    = N_W'(IDX) < n;
        cand      = active && (up == WANT_UP) && !item_in.hit
                    && ((item_in.h == H_W'(0)) || (item_in.h == H_W'(1)));
        item_next = item_in;
        if (cand)
        begin
            if (item_in.cnt == CNT_W'(1))
            begin
                item_next.hit    = 1'b1;
                item_next.pos    = POS_W'(IDX);
                item_next.w[IDX] = !WANT_UP;
            end
            else if (item_in.cnt != '0)
            begin
                item_next.cnt = item_in.cnt - CNT_W'(1);
            end
        end
        if (active)
        begin
            item_next.h = up ? (item_in.h + H_W'(1)) : (item_in.h - H_W'(1));
        end
    end

    // stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_reg <= '0;
        end
        else if (adv)
        begin
            item_reg <= item_next;
        end
    end

    assign item_out = item_reg;

endmodule

// File: rtl/dyck_word_flip_pair.sv
// dyck_word_flip_pair: top level, four rows of cells for the two step flips
//
//   channel  | handshake                | payload
//   ---------+--------------------------+-----------------------------------------
//   in       | in_valid / in_stall      | step_word
//   out      | out_valid / out_stall    | after_first_word, first_position,
//            |                          | after_second_word, second_position, status
//   cfg      | cfg_valid / cfg_ready    | half_length
//
// one word enters per cycle while in_stall is low; a word leaves through the output register
// after one cell per step position in each of four rows (count, select, count, select).
// reset clears all valid bits and sets half_length to 16.
// the whole chain moves together: while a result waits under out_stall, in_stall is high.
module dyck_word_flip_pair
    import dwfp_pkg::*;
#(
    parameter int MAX_HALF = DWFP_MAX_HALF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [WORD_W-1:0]   step_word,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [WORD_W-1:0]   after_first_word,
    output logic [POS_W-1:0]    first_position,
    output logic [WORD_W-1:0]   after_second_word,
    output logic [POS_W-1:0]    second_position,
    output logic [1:0]          status,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [HALF_W-1:0]   half_length
);

    localparam int HALF_CAP = (MAX_HALF > 16) ? 16 : MAX_HALF;
    localparam int NCELL    = 2 * HALF_CAP;
    localparam logic [HALF_W-1:0] HALF_CAP_V = HALF_W'(HALF_CAP);

    logic [HALF_W-1:0] half_reg;
    logic [HALF_W-1:0] m_eff;
    logic [N_W-1:0]    n;
    logic              adv;

    dwfp_item_t a_chain [0:NCELL];
    dwfp_item_t b_chain [0:NCELL];
    dwfp_item_t c_chain [0:NCELL];
    dwfp_item_t d_chain [0:NCELL];

    logic              out_vld_reg;
    logic [WORD_W-1:0] first_word_reg;
    logic [POS_W-1:0]  first_pos_reg;
    logic [WORD_W-1:0] second_word_reg;
    logic [POS_W-1:0]  second_pos_reg;
    logic [1:0]        status_reg;

    // configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg <= HALF_W'(16);
        end
        else if (cfg_valid && cfg_ready)
        begin
            half_reg <= half_length;
        end
    end

    // step count, clamped to the cell count
    assign m_eff = (half_reg > HALF_CAP_V) ? HALF_CAP_V : half_reg;
    assign n     = {m_eff, 1'b0};

    // chain advances when the output register is free or being taken
    assign adv      = !out_vld_reg || !out_stall;
    assign in_stall = !adv;

    // entry of the first counting row
    always_comb
    begin
        a_chain[0]     = '0;
        a_chain[0].vld = in_valid;
        a_chain[0].w   = step_word;
    end

    // first selection row: target is d0 + 1
    always_comb
    begin
        b_chain[0]     = a_chain[NCELL];
        b_chain[0].h   = '0;
        b_chain[0].hit = 1'b0;
        b_chain[0].cnt = a_chain[NCELL].cnt + CNT_W'(1);
    end

    // second counting row works on the first result
    always_comb
    begin
        c_chain[0]           = b_chain[NCELL];
        c_chain[0].first_hit = b_chain[NCELL].hit;
        c_chain[0].y         = b_chain[NCELL].w;
        c_chain[0].a         = b_chain[NCELL].pos;
        c_chain[0].h         = '0;
        c_chain[0].cnt       = '0;
        c_chain[0].hit       = 1'b0;
    end

    // second selection row: target is u1
    always_comb
    begin
        d_chain[0]     = c_chain[NCELL];
        d_chain[0].h   = '0;
        d_chain[0].hit = 1'b0;
    end

    // the four rows of cells
    genvar gi;
    generate
        for (gi = 0; gi < NCELL; gi++)
        begin : g_cell
            dwfp_count_cell #(.IDX(gi), .WANT_UP(1'b0)) u_cnt_down (
                .clk      (clk),
                .rst_n    (rst_n),
                .adv      (adv),
                .n        (n),
                .item_in  (a_chain[gi]),
                .item_out (a_chain[gi+1])
            );
            dwfp_select_cell #(.IDX(gi), .WANT_UP(1'b0)) u_sel_down (
                .clk      (clk),
                .rst_n    (rst_n),
                .adv      (adv),
                .n        (n),
                .item_in  (b_chain[gi]),
                .item_out (b_chain[gi+1])
            );
            dwfp_count_cell #(.IDX(gi), .WANT_UP(1'b1)) u_cnt_up (
                .clk      (clk),
                .rst_n    (rst_n),
                .adv      (adv),
                .n        (n),
                .item_in  (c_chain[gi]),
                .item_out (c_chain[gi+1])
            );
            dwfp_select_cell #(.IDX(gi), .WANT_UP(1'b1)) u_sel_up (
                .clk      (clk),
                .rst_n    (rst_n),
                .adv      (adv),
                .n        (n),
                .item_in  (d_chain[gi]),
                .item_out (d_chain[gi+1])
            );
        end
    endgenerate

    // output register with status and zeroing of missing results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_vld_reg <= d_chain[NCELL].vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (!d_chain[NCELL].first_hit)
            begin
                first_word_reg  <= '0;
                first_pos_reg   <= '0;
                second_word_reg <= '0;
                second_pos_reg  <= '0;
                status_reg      <= STATUS_NO_FIRST;
            end
            else if (!d_chain[NCELL].hit)
            begin
                first_word_reg  <= d_chain[NCELL].y;
                first_pos_reg   <= d_chain[NCELL].a;
                second_word_reg <= '0;
                second_pos_reg  <= '0;
                status_reg      <= STATUS_NO_SECOND;
            end
            else
            begin
                first_word_reg  <= d_chain[NCELL].y;
                first_pos_reg   <= d_chain[NCELL].a;
                second_word_reg <= d_chain[NCELL].w;
                second_pos_reg  <= d_chain[NCELL].pos;
                status_reg      <= STATUS_OK;
            end
        end
    end

    assign out_valid         = out_vld_reg;
    assign after_first_word  = first_word_reg;
    assign first_position    = first_pos_reg;
    assign after_second_word = second_word_reg;
    assign second_position   = second_pos_reg;
    assign status            = status_reg;

    // a missing first flip leaves every word and position at zero
    a_no_first_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == STATUS_NO_FIRST) |->
        (after_first_word == '0 && first_position == '0
         && after_second_word == '0 && second_position == '0))
        else $error("fields not zero when first flip missing");

    // the first flip always leaves an up-step at its position
    a_first_is_up: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == STATUS_OK || status == STATUS_NO_SECOND)) |->
        after_first_word[first_position])
        else $error("first flip did not produce an up-step");

    // the second flip turns an up-step of the first word into a down-step
    a_second_flip: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == STATUS_OK) |->
        (after_first_word[second_position] && !after_second_word[second_position]))
        else $error("second flip inconsistent with first word");

    // the chain only holds back input while a result is stalled
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a stalled result");

endmodule

// File: bench/tb_dyck_word_flip_pair.sv
// tb_dyck_word_flip_pair: self-checking bench for the dyck word flip pair block
`timescale 1ns / 1ps

module tb_dyck_word_flip_pair
    import dwfp_pkg::*;
();

    // one expected result
    typedef struct {
        logic [WORD_W-1:0] first_word;
        logic [POS_W-1:0]  first_pos;
        logic [WORD_W-1:0] second_word;
        logic [POS_W-1:0]  second_pos;
        logic [1:0]        stat;
    } flip_result_t;

    localparam int PIPE_CYCLES = 4 * 2 * 16 + 1;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [WORD_W-1:0]   step_word = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [WORD_W-1:0]   after_first_word;
    logic [POS_W-1:0]    first_position;
    logic [WORD_W-1:0]   after_second_word;
    logic [POS_W-1:0]    second_position;
    logic [1:0]          status;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [HALF_W-1:0]   cfg_half_length = HALF_W'(16);

    logic [WORD_W-1:0]   pending_words[$];
    flip_result_t        due_results[$];
    logic [HALF_W-1:0]   cur_half = HALF_W'(16);
    int                  send_idle_pct = 0;
    int                  recv_stall_pct = 0;
    int                  mismatches = 0;
    logic                in_acc = 1'b0;
    logic                hold_go = 1'b0;
    logic                hold_seen = 1'b0;
    int                  hold_left = 0;

    dyck_word_flip_pair u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .step_word         (step_word),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .after_first_word  (after_first_word),
        .first_position    (first_position),
        .after_second_word (after_second_word),
        .second_position   (second_position),
        .status            (status),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .half_length       (cfg_half_length)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // run limit
    initial
    begin
        #1000000;
        $display("tb_dyck_word_flip_pair failed");
        $finish;
    end

    // flip the chosen step of one kind; returns 1 when a step was found
    function automatic bit flip_step(input logic [WORD_W-1:0] w, input int n,
                                     input bit want_up, output logic [WORD_W-1:0] res,
                                     output logic [POS_W-1:0] pos);
        int lvl_at[32];
        int lvl;
        int cnt;
        int target;
        int ord;
        bit found;
        lvl = 0;
        cnt = 0;
        ord = 0;
        found = 1'b0;
        res = '0;
        pos = '0;
        // heights before each step and the count that picks the target
        for (int i = 0; i < n; i++)
        begin
            lvl_at[i] = lvl;
            if (want_up ? (w[i] && lvl == 1) : (!w[i] && lvl == 0))
                cnt++;
            lvl += w[i] ? 1 : -1;
        end
        target = want_up ? cnt : cnt + 1;
        // walk the candidates at height 0 or 1 to the target one
        for (int i = 0; i < n && !found; i++)
        begin
            if (w[i] == want_up && (lvl_at[i] == 0 || lvl_at[i] == 1))
            begin
                ord++;
                if (ord == target)
                begin
                    found = 1'b1;
                    res = w;
                    res[i] = !want_up;
                    pos = POS_W'(i);
                end
            end
        end
        return found;
    endfunction

    // both flips of one word under a given half length
    function automatic flip_result_t flip_pair_of(input logic [WORD_W-1:0] w,
                                                  input logic [HALF_W-1:0] half);
        flip_result_t r;
        logic [WORD_W-1:0] y;
        logic [WORD_W-1:0] z;
        logic [POS_W-1:0]  a;
        logic [POS_W-1:0]  b;
        int m;
        m = (half > 16) ? 16 : int'(half);
        r = '{'0, '0, '0, '0, STATUS_OK};
        if (!flip_step(w, 2 * m, 1'b0, y, a))
        begin
            r.stat = STATUS_NO_FIRST;
            return r;
        end
        r.first_word = y;
        r.first_pos  = a;
        if (!flip_step(y, 2 * m, 1'b1, z, b))
        begin
            r.stat = STATUS_NO_SECOND;
            return r;
        end
        r.second_word = z;
        r.second_pos  = b;
        return r;
    endfunction

    // random balanced path of n steps in the low bits
    function automatic logic [WORD_W-1:0] random_dyck(input int n);
        logic [WORD_W-1:0] w;
        int ups;
        int downs;
        int lvl;
        w = '0;
        ups = n / 2;
        downs = n / 2;
        lvl = 0;
        for (int i = 0; i < n; i++)
        begin
            if (downs == 0 || (ups > 0 && (lvl == 0 || $urandom_range(1) == 1)))
            begin
                w[i] = 1'b1;
                ups--;
                lvl++;
            end
            else
            begin
                downs--;
                lvl--;
            end
        end
        return w;
    endfunction

    // mostly balanced paths with random upper bits, some with one bit broken, some noise
    function automatic logic [WORD_W-1:0] random_word();
        logic [WORD_W-1:0] mask;
        logic [WORD_W-1:0] w;
        int n;
        int pick;
        n = 2 * ((cur_half > 16) ? 16 : int'(cur_half));
        mask = (n == 32) ? '1 : ((WORD_W'(1) << n) - 1);
        pick = $urandom_range(99);
        w = ($urandom() & ~mask) | random_dyck(n);
        if (pick >= 70 && pick < 85 && n > 0)
            w[$urandom_range(n - 1)] ^= 1'b1;
        else if (pick >= 85)
            w = $urandom();
        return w;
    endfunction

    function automatic void check_field(input string name, input logic [WORD_W-1:0] exp_v,
                                        input logic [WORD_W-1:0] got_v);
        if (exp_v !== got_v)
        begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, exp_v, got_v);
            mismatches++;
        end
    endfunction

    // input acceptance, prediction and result checking at the rising edge
    always @(posedge clk)
    begin
        flip_result_t e;
        in_acc <= rst_n && in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
            due_results.insert(due_results.size(), flip_pair_of(step_word, cur_half));
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_results.size() == 0)
            begin
                $display("%0t ns: unexpected result, expected none, actual word %h status %0d",
                         $time, after_first_word, status);
                mismatches++;
            end
            else
            begin
                e = due_results.pop_front();
                check_field("after_first_word", e.first_word, after_first_word);
                check_field("first_position", WORD_W'(e.first_pos), WORD_W'(first_position));
                check_field("after_second_word", e.second_word, after_second_word);
                check_field("second_position", WORD_W'(e.second_pos), WORD_W'(second_position));
                check_field("status", WORD_W'(e.stat), WORD_W'(status));
            end
        end
    end

    // sender: next word once the current transaction is taken
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_acc))
        begin
            if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_valid  <= 1'b1;
                step_word <= pending_words.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver: random stall, or a long hold-off when requested
    always @(negedge clk)
    begin
        if (hold_go != hold_seen)
        begin
            hold_seen <= hold_go;
            hold_left <= 3 * PIPE_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic wait_drained();
        while (pending_words.size() != 0 || in_valid || due_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_half(input logic [HALF_W-1:0] v);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_half_length = v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cur_half = v;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // idle mode: 0 none, 1 sender idle, 2 receiver stalls, 3 both lightly
    task automatic set_idling(input int mode);
        @(posedge clk);
        send_idle_pct  = (mode == 1) ? 50 : (mode == 3) ? 7 : 0;
        recv_stall_pct = (mode == 2) ? 50 : (mode == 3) ? 7 : 0;
    endtask

    initial
    begin
        logic [HALF_W-1:0] phase_half[8];
        logic [WORD_W-1:0] directed[$];
        phase_half = '{HALF_W'(1), HALF_W'(31), HALF_W'(0), HALF_W'(7),
                       HALF_W'(2), HALF_W'(12), HALF_W'(16), HALF_W'(20)};
        directed = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA,
                     32'h0000_FFFF, 32'hFFFF_0000, 32'h00FF_00FF, 32'h3333_3333,
                     32'hCCCC_CCCC, 32'h0F0F_0F0F, 32'h8000_0000, 32'h0000_0001,
                     32'h7FFF_FFFF, 32'hFFFF_FFFE, 32'h5555_AAAA, 32'hAAAA_5555,
                     32'h0000_0003, 32'h5555_5556};
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed words, then four balanced paths with one bit flipped, at the reset half length
        set_idling(0);
        foreach (directed[i])
            pending_words.insert(pending_words.size(), directed[i]);
        repeat (4)
            pending_words.insert(pending_words.size(),
                                 random_dyck(32) ^ (32'h1 << $urandom_range(31)));
        wait_drained();

        // long receiver hold-off while the sender keeps offering
        write_half(HALF_W'(16));
        set_idling(0);
        hold_go = ~hold_go;
        repeat (160) pending_words.insert(pending_words.size(), random_word());
        wait_drained();

        // random phases over several half lengths and idling modes
        foreach (phase_half[p])
        begin
            write_half(phase_half[p]);
            set_idling(p % 4);
            repeat (30) pending_words.insert(pending_words.size(), random_word());
            wait_drained();
        end

        repeat (PIPE_CYCLES + 20) @(posedge clk);
        if (mismatches == 0 && due_results.size() == 0)
            $display("tb_dyck_word_flip_pair passed");
        else
            $display("tb_dyck_word_flip_pair failed");
        $finish;
    end

endmodule
